// File: rtl/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg
// Shared types, constants and calendar helpers for the windowed date
// day-count compare core.
// ----------------------------------------------------------------------------
package wdc_pkg;

  typedef enum logic [1:0] {
    ACT_DIFF    = 2'd0,
    ACT_ORDER   = 2'd1,
    ACT_WEEKDAY = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam int YEAR_DIGIT_W = 7;
  localparam int YEAR_OFF_W   = 8;   // resolved year minus 1900, 0..226
  localparam int DAY_NUM_W    = 17;
  localparam int COUNT_W      = 32;

  localparam logic [YEAR_DIGIT_W-1:0] PIVOT_RESET   = 7'd50;
  // 2000 - 1900 and 2100 - 1900 as year offsets
  localparam logic [YEAR_OFF_W-1:0]   OFF_2000      = 8'd100;
  localparam logic [YEAR_OFF_W-1:0]   OFF_2100      = 8'd200;
  localparam logic [YEAR_OFF_W-1:0]   MAX_SPAN      = 8'd100;
  localparam logic [DAY_NUM_W-1:0]    DAYS_PER_YEAR = 17'd365;
  localparam logic [2:0]              WEEK_LEN      = 3'd7;

  typedef struct packed {
    logic [DAY_NUM_W-1:0]  day_num;
    logic [YEAR_OFF_W-1:0] year_off;
  } lane_t;

  // Leap years in [1900, 1900 + off - 1]; valid for off up to 252.
  function automatic logic [5:0] leaps_from_base(input logic [YEAR_OFF_W-1:0] off);
    logic [8:0] quads;
    logic [5:0] skips;
    quads = ({1'b0, off} + 9'd3) >> 2;
    skips = 6'(off != '0) + 6'(off > OFF_2100);
    return 6'(quads) - skips;
  endfunction

  function automatic logic is_leap_off(input logic [YEAR_OFF_W-1:0] off);
    return (off[1:0] == 2'd0) && (off != '0) && (off != OFF_2100);
  endfunction

  // Days of the months before the given one; months past December clamp.
  function automatic logic [8:0] month_days_before(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    return days;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one final subtract.
  function automatic logic [2:0] mod7(input logic [DAY_NUM_W-1:0] n);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(n[2:0]) + 6'(n[5:3]) + 6'(n[8:6]) + 6'(n[11:9]) + 6'(n[14:12])
         + 6'(n[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    return (s2 >= 4'(WEEK_LEN)) ? 3'(s2 - 4'(WEEK_LEN)) : s2[2:0];
  endfunction

endpackage

// File: rtl/wdc_lane.sv
// ----------------------------------------------------------------------------
// wdc_lane
// One date lane: windows the year and forms the day number since 1900,
// registered.
// ----------------------------------------------------------------------------
module wdc_lane (
  input  logic          clk,
  input  logic          en,
  input  logic [6:0]    pivot,
  input  logic [6:0]    year_digits,
  input  logic [3:0]    month,
  input  logic [4:0]    day,
  output wdc_pkg::lane_t result
);
  import wdc_pkg::*;

  logic [YEAR_OFF_W-1:0] year_off;
  logic                  leap_day;
  lane_t                 result_next;

  always_comb begin
    year_off = (year_digits < pivot) ? ({1'b0, year_digits} + OFF_2000)
                                     : {1'b0, year_digits};
    leap_day = (month >= 4'd3) && is_leap_off(year_off);
    result_next.year_off = year_off;
    result_next.day_num  = DAY_NUM_W'(day)
                         + DAY_NUM_W'(year_off) * DAYS_PER_YEAR
                         + DAY_NUM_W'(leaps_from_base(year_off))
                         + DAY_NUM_W'(month_days_before(month))
                         + DAY_NUM_W'(leap_day);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/wdc_merge.sv
// ----------------------------------------------------------------------------
// wdc_merge
// Combines the two lane results per action, keeps the running violation
// count and leap tally, and registers the outgoing result.
// ----------------------------------------------------------------------------
module wdc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wdc_pkg::action_t    action,
  input  wdc_pkg::lane_t      first,
  input  wdc_pkg::lane_t      second,
  output logic                status,
  output logic signed [16:0]  day_difference,
  output logic [2:0]          weekday,
  output logic [31:0]         violation_count,
  output logic [31:0]         leap_tally
);
  import wdc_pkg::*;

  logic [YEAR_OFF_W-1:0] lo_off;
  logic [YEAR_OFF_W-1:0] hi_off;
  logic [5:0]            span_leaps;
  logic                  status_next;
  logic [DAY_NUM_W-1:0]  diff_next;
  logic [2:0]            weekday_next;
  logic [COUNT_W-1:0]    violation_count_next;
  logic [COUNT_W-1:0]    leap_tally_next;

  always_comb begin
    lo_off = (first.year_off < second.year_off) ? first.year_off : second.year_off;
    hi_off = (first.year_off < second.year_off) ? second.year_off : first.year_off;
    // leap years in the inclusive span [lo, hi]
    span_leaps = leaps_from_base(hi_off + 8'd1) - leaps_from_base(lo_off);

    status_next          = 1'b0;
    diff_next            = '0;
    weekday_next         = '0;
    violation_count_next = violation_count;
    leap_tally_next      = leap_tally;
    case (action)
      ACT_DIFF: begin
        if ((hi_off - lo_off) <= MAX_SPAN) begin
          diff_next       = second.day_num - first.day_num;
          leap_tally_next = leap_tally + COUNT_W'(span_leaps);
        end
      end
      ACT_ORDER: begin
        if (first.day_num > second.day_num) begin
          status_next          = 1'b1;
          violation_count_next = violation_count + 32'd1;
        end
      end
      ACT_WEEKDAY: begin
        weekday_next = mod7(first.day_num);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      violation_count <= '0;
      leap_tally      <= '0;
    end else if (load) begin
      violation_count <= violation_count_next;
      leap_tally      <= leap_tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= status_next;
      day_difference <= signed'(diff_next);
      weekday        <= weekday_next;
    end
  end

endmodule

// File: rtl/windowed_date_day_count_compare_core.sv
// ----------------------------------------------------------------------------
// windowed_date_day_count_compare_core
// Two-digit-year date pair compare: day difference, order check, weekday.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns one result
// per request: the lane stage forms both day numbers in two parallel date
// lanes and registers them, the merge stage merges them and updates the
// violation count and the leap tally. The output register and the lane
// register both advance whenever downstream is not stalling, so a full
// stream runs at one request per cycle; in_stall rises only when out_stall
// holds a result and the lane stage is occupied. Write window_pivot only
// while no request is in flight; cfg_ready is always high.
module windowed_date_day_count_compare_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [6:0]         first_year_digits,
  input  logic [3:0]         first_month,
  input  logic [4:0]         first_day,
  input  logic [6:0]         second_year_digits,
  input  logic [3:0]         second_month,
  input  logic [4:0]         second_day,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic signed [16:0] day_difference,
  output logic [2:0]         weekday,
  output logic [31:0]        violation_count,
  output logic [31:0]        leap_tally,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         window_pivot
);
  import wdc_pkg::*;

  logic [YEAR_DIGIT_W-1:0] pivot;
  logic                    lane_valid;
  action_t                 lane_action;
  lane_t                   first_res;
  lane_t                   second_res;
  logic                    out_load;
  logic                    lane_en;

  assign cfg_ready = 1'b1;
  assign out_load  = lane_valid && (!out_valid || !out_stall);
  assign lane_en   = !lane_valid || out_load;
  assign in_stall  = !lane_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= PIVOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pivot <= window_pivot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (lane_en) begin
        lane_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lane_en && in_valid) begin
      lane_action <= action_t'(action);
    end
  end

  wdc_lane u_first_lane (
    .clk         (clk),
    .en          (lane_en && in_valid),
    .pivot       (pivot),
    .year_digits (first_year_digits),
    .month       (first_month),
    .day         (first_day),
    .result      (first_res)
  );

  wdc_lane u_second_lane (
    .clk         (clk),
    .en          (lane_en && in_valid),
    .pivot       (pivot),
    .year_digits (second_year_digits),
    .month       (second_month),
    .day         (second_day),
    .result      (second_res)
  );

  wdc_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .load            (out_load),
    .action          (lane_action),
    .first           (first_res),
    .second          (second_res),
    .status          (status),
    .day_difference  (day_difference),
    .weekday         (weekday),
    .violation_count (violation_count),
    .leap_tally      (leap_tally)
  );

endmodule

// File: rtl/wdc_checker.sv
// ----------------------------------------------------------------------------
// wdc_checker
// Port-level checks for the windowed date day-count compare core.
// ----------------------------------------------------------------------------
module wdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic               status,
  input logic signed [16:0] day_difference,
  input logic [2:0]         weekday,
  input logic [31:0]        violation_count,
  input logic [31:0]        leap_tally
);

  // hold a stalled result, counters included
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(day_difference) && $stable(weekday)
      && $stable(violation_count) && $stable(leap_tally))
    else $error("stalled result changed");

  // violation count advances by at most one per result
  a_viol_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (violation_count == $past(violation_count))
      || (violation_count == $past(violation_count) + 32'd1))
    else $error("violation count jumped");

  // a flagged order check carries no difference or weekday
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (day_difference == '0) && (weekday == 3'd0))
    else $error("status with other result fields");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= 3'd6) && ((weekday == 3'd0) || (day_difference == '0)))
    else $error("weekday out of range or mixed with difference");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && (violation_count == '0) && (leap_tally == '0))
    else $error("state not cleared by reset");

endmodule

bind windowed_date_day_count_compare_core wdc_checker u_wdc_checker (.*);

// File: tb/sv/windowed_date_day_count_compare_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_date_day_count_compare_core_tb
// Drives date-pair requests through the core under several year-window
// pivots and compares every result against a cycle-free calendar predictor
// kept in step with the core's running violation count and leap tally.
// ----------------------------------------------------------------------------
module windowed_date_day_count_compare_core_tb;

  import wdc_pkg::*;

  typedef struct {
    logic               status;
    logic signed [16:0] day_difference;
    logic [2:0]         weekday;
    logic [31:0]        violation_count;
    logic [31:0]        leap_tally;
  } date_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         action;
  logic [6:0]         first_year_digits;
  logic [3:0]         first_month;
  logic [4:0]         first_day;
  logic [6:0]         second_year_digits;
  logic [3:0]         second_month;
  logic [4:0]         second_day;
  logic               out_valid;
  logic               out_stall;
  logic               status;
  logic signed [16:0] day_difference;
  logic [2:0]         weekday;
  logic [31:0]        violation_count;
  logic [31:0]        leap_tally;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         window_pivot;

  date_result_t pending_results[$];
  int           error_count = 0;
  bit           no_idle     = 1'b0;

  // Predictor state
  logic [6:0]  pivot_setting;
  logic [31:0] order_violations;
  logic [31:0] leap_sum;

  windowed_date_day_count_compare_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .first_year_digits  (first_year_digits),
    .first_month        (first_month),
    .first_day          (first_day),
    .second_year_digits (second_year_digits),
    .second_month       (second_month),
    .second_day         (second_day),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .day_difference     (day_difference),
    .weekday            (weekday),
    .violation_count    (violation_count),
    .leap_tally         (leap_tally),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .window_pivot       (window_pivot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned leaps_upto(input int unsigned year);
    int unsigned prev;
    prev = year - 1;
    return prev / 4 - prev / 100 + prev / 400;
  endfunction

  function automatic bit leap_year(input int unsigned year);
    if (year % 100 == 0) return (year % 400) == 0;
    return (year % 4) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned month);
    case (month)
      2:              return 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic int unsigned resolved_year(input logic [6:0] digits);
    return (digits < pivot_setting) ? 2000 + digits : 1900 + digits;
  endfunction

  // Days since the last day of 1899; day taken as given, months past December clamp.
  function automatic int unsigned day_index(input int unsigned year,
                                            input logic [3:0] month,
                                            input logic [4:0] day);
    int unsigned total;
    int unsigned last;
    total = day + 365 * (year - 1900) + leaps_upto(year) - leaps_upto(1900);
    last  = (month > 12) ? 12 : month;
    for (int unsigned m = 1; m < last; m++) total += month_length(m);
    if (last > 2 && leap_year(year)) total += 1;
    return total;
  endfunction

  function automatic date_result_t compute_date_result(
      input action_t act,
      input logic [6:0] fy, input logic [3:0] fm, input logic [4:0] fd,
      input logic [6:0] sy, input logic [3:0] sm, input logic [4:0] sd);
    date_result_t res;
    int unsigned  y1, y2, n1, n2, lo, hi;
    y1 = resolved_year(fy);
    y2 = resolved_year(sy);
    n1 = day_index(y1, fm, fd);
    n2 = day_index(y2, sm, sd);
    res.status         = 1'b0;
    res.day_difference = '0;
    res.weekday        = '0;
    case (act)
      ACT_DIFF: begin
        lo = (y1 < y2) ? y1 : y2;
        hi = (y1 < y2) ? y2 : y1;
        // spans beyond a century leave the tally alone
        if (hi - lo <= 100) begin
          leap_sum           = leap_sum + (leaps_upto(hi + 1) - leaps_upto(lo));
          res.day_difference = 17'(n2 - n1);
        end
      end
      ACT_ORDER: begin
        if (n1 > n2) begin
          res.status       = 1'b1;
          order_violations = order_violations + 1;
        end
      end
      ACT_WEEKDAY: res.weekday = 3'(n1 % 7);
      default: ;
    endcase
    res.violation_count = order_violations;
    res.leap_tally      = leap_sum;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic int pick_idle_len();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_date_pair(
      input action_t act,
      input logic [6:0] fy, input logic [3:0] fm, input logic [4:0] fd,
      input logic [6:0] sy, input logic [3:0] sm, input logic [4:0] sd);
    int gap;
    gap = pick_idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    action             = act;
    first_year_digits  = fy;
    first_month        = fm;
    first_day          = fd;
    second_year_digits = sy;
    second_month       = sm;
    second_day         = sd;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compute_date_result(act, fy, fm, fd, sy, sm, sd));
  endtask

  // Drop valid and let every outstanding request come back, plus pipeline slack.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pivot(input logic [6:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid    = 1'b1;
    window_pivot = value;
    do @(posedge clk); while (!cfg_ready);
    pivot_setting = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stall the result side in runs, with the result side open between runs.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall  = 1'b0;
        stall_left = pick_idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint expected,
                             input longint actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", exp_res.status, status);
        check_field("day_difference", exp_res.day_difference, day_difference);
        check_field("weekday", exp_res.weekday, weekday);
        check_field("violation_count", exp_res.violation_count, violation_count);
        check_field("leap_tally", exp_res.leap_tally, leap_tally);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_day_difference();
    load_pivot(7'd50);
    send_date_pair(ACT_DIFF, 7'd0, 4'd1, 5'd1, 7'd99, 4'd12, 5'd31);
    send_date_pair(ACT_DIFF, 7'd49, 4'd12, 5'd31, 7'd50, 4'd1, 5'd1);
    send_date_pair(ACT_DIFF, 7'd127, 4'd15, 5'd31, 7'd0, 4'd0, 5'd0);
  endtask

  task automatic test_century_span();
    // pivot 0 puts every year in the 1900s; digits past 99 reach 2000+
    load_pivot(7'd0);
    send_date_pair(ACT_DIFF, 7'd0, 4'd1, 5'd1, 7'd100, 4'd1, 5'd1);
    send_date_pair(ACT_DIFF, 7'd0, 4'd1, 5'd1, 7'd101, 4'd1, 5'd1);
    send_date_pair(ACT_DIFF, 7'd127, 4'd12, 5'd31, 7'd0, 4'd1, 5'd1);
    // top pivot: 2100 is not a leap year, 2096 is
    load_pivot(7'd127);
    send_date_pair(ACT_DIFF, 7'd100, 4'd3, 5'd1, 7'd96, 4'd2, 5'd29);
    send_date_pair(ACT_DIFF, 7'd126, 4'd12, 5'd31, 7'd127, 4'd1, 5'd1);
  endtask

  task automatic test_order_check();
    load_pivot(7'd50);
    send_date_pair(ACT_ORDER, 7'd99, 4'd12, 5'd31, 7'd0, 4'd1, 5'd1);
    send_date_pair(ACT_ORDER, 7'd0, 4'd1, 5'd1, 7'd99, 4'd12, 5'd31);
    send_date_pair(ACT_ORDER, 7'd20, 4'd6, 5'd15, 7'd20, 4'd6, 5'd15);
    send_date_pair(ACT_ORDER, 7'd20, 4'd3, 5'd0, 7'd20, 4'd2, 5'd31);
    send_date_pair(ACT_ORDER, 7'd127, 4'd15, 5'd31, 7'd126, 4'd0, 5'd0);
  endtask

  task automatic test_weekday();
    send_date_pair(ACT_WEEKDAY, 7'd0, 4'd1, 5'd1, 7'd0, 4'd1, 5'd1);
    send_date_pair(ACT_WEEKDAY, 7'd50, 4'd1, 5'd1, 7'd127, 4'd15, 5'd31);
    send_date_pair(ACT_WEEKDAY, 7'd127, 4'd15, 5'd31, 7'd0, 4'd0, 5'd0);
    send_date_pair(ACT_WEEKDAY, 7'd0, 4'd0, 5'd0, 7'd99, 4'd12, 5'd31);
  endtask

  task automatic test_unused_action();
    send_date_pair(ACT_NONE, 7'd10, 4'd5, 5'd20, 7'd3, 4'd7, 5'd4);
    send_date_pair(ACT_NONE, 7'd127, 4'd15, 5'd31, 7'd0, 4'd0, 5'd0);
  endtask

  task automatic test_month_and_day_edges();
    send_date_pair(ACT_DIFF, 7'd24, 4'd0, 5'd0, 7'd24, 4'd13, 5'd31);
    send_date_pair(ACT_ORDER, 7'd24, 4'd14, 5'd1, 7'd24, 4'd15, 5'd1);
    send_date_pair(ACT_WEEKDAY, 7'd24, 4'd2, 5'd31, 7'd23, 4'd2, 5'd31);
    send_date_pair(ACT_DIFF, 7'd0, 4'd2, 5'd29, 7'd0, 4'd3, 5'd1);
  endtask

  function automatic logic [6:0] rand_year_digits();
    return ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                        : 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [3:0] rand_month();
    return ($urandom_range(0, 99) < 90) ? 4'($urandom_range(1, 12))
                                        : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [4:0] rand_day();
    return ($urandom_range(0, 99) < 90) ? 5'($urandom_range(1, 31))
                                        : 5'($urandom_range(0, 31));
  endfunction

  task automatic test_random_pairs(input int items_per_pivot);
    logic [6:0] pivots [6];
    logic [6:0] fy, sy;
    logic [3:0] fm, sm;
    logic [4:0] fd, sd;
    action_t    act;
    pivots = '{7'd0, 7'd127, 7'd100, 7'd50, 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127))};
    foreach (pivots[p]) begin
      load_pivot(pivots[p]);
      for (int i = 0; i < items_per_pivot; i++) begin
        // hold a no-idle stretch for blocks of 50 requests now and then
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        act = ($urandom_range(0, 9) == 0) ? ACT_NONE
                                          : action_t'($urandom_range(0, 2));
        fy = rand_year_digits();
        fm = rand_month();
        fd = rand_day();
        if ($urandom_range(0, 3) == 0) begin
          // nearby second date keeps the order check close to equality
          sy = fy;
          sm = ($urandom_range(0, 1) == 0) ? fm : rand_month();
          sd = rand_day();
        end else begin
          sy = rand_year_digits();
          sm = rand_month();
          sd = rand_day();
        end
        send_date_pair(act, fy, fm, fd, sy, sm, sd);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    action             = '0;
    first_year_digits  = '0;
    first_month        = '0;
    first_day          = '0;
    second_year_digits = '0;
    second_month       = '0;
    second_day         = '0;
    cfg_valid          = 1'b0;
    window_pivot       = '0;
    pivot_setting      = PIVOT_RESET;
    order_violations   = '0;
    leap_sum           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_day_difference();
    test_century_span();
    test_order_check();
    test_weekday();
    test_unused_action();
    test_month_and_day_edges();
    test_random_pairs(325);

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
